// ===== rtl/asgr_pkg.sv =====
// Shared types, character codes, SGR codes and palette functions of the SGR color decoder.
`timescale 1ns / 1ps
package asgr_pkg;

  typedef logic [23:0] rgb_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0] glyph_code;
    rgb_t       fg_rgb;
    rgb_t       bg_rgb;
    logic       last_of_run;
  } out_t;

  // Status of the parameter walker as seen by the parser.
  typedef struct packed {
    logic busy;
    logic done;
    rgb_t fg;
    rgb_t bg;
  } walk_stat_t;

  localparam logic [7:0] CHAR_ESC   = 8'h1B;
  localparam logic [7:0] CHAR_LBRK  = 8'h5B;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_M     = 8'h6D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;

  localparam logic [15:0] SGR_RESET      = 16'd0;
  localparam logic [15:0] SGR_EXT_RGB    = 16'd2;
  localparam logic [15:0] SGR_FG_EXT     = 16'd38;
  localparam logic [15:0] SGR_FG_DEFAULT = 16'd39;
  localparam logic [15:0] SGR_BG_EXT     = 16'd48;
  localparam logic [15:0] SGR_BG_DEFAULT = 16'd49;
  localparam logic [15:0] SGR_FG_BASIC   = 16'd30;
  localparam logic [15:0] SGR_BG_BASIC   = 16'd40;
  localparam logic [15:0] SGR_FG_BRIGHT  = 16'd90;
  localparam logic [15:0] SGR_BG_BRIGHT  = 16'd100;

  localparam logic [15:0] ACC_MAX = 16'hFFFF;
  localparam rgb_t FG_RESET = 24'hFFFFFF;
  localparam rgb_t BG_RESET = 24'h000000;

  function automatic rgb_t pal_basic(input logic [2:0] idx);
    rgb_t c;
    case (idx)
      3'd0: c = 24'h000000;
      3'd1: c = 24'hCD0000;
      3'd2: c = 24'h00CD00;
      3'd3: c = 24'hCDCD00;
      3'd4: c = 24'h0000EE;
      3'd5: c = 24'hCD00CD;
      3'd6: c = 24'h00CDCD;
      default: c = 24'hE5E5E5;
    endcase
    return c;
  endfunction

  function automatic rgb_t pal_bright(input logic [2:0] idx);
    rgb_t c;
    case (idx)
      3'd0: c = 24'h7F7F7F;
      3'd1: c = 24'hFF0000;
      3'd2: c = 24'h00FF00;
      3'd3: c = 24'hFFFF00;
      3'd4: c = 24'h5C5CFF;
      3'd5: c = 24'hFF00FF;
      3'd6: c = 24'h00FFFF;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] clamp8(input logic [15:0] v);
    return (v > 16'd255) ? 8'hFF : v[7:0];
  endfunction

endpackage

// ===== rtl/asgr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module asgr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/asgr_walk.sv =====
// Walks the stored SGR parameters one per cycle and computes the new colors.
`timescale 1ns / 1ps
module asgr_walk #(
  parameter int MAX_PARAMS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [$clog2(MAX_PARAMS + 1)-1:0] count_i,
  input  asgr_pkg::rgb_t      fg_i,
  input  asgr_pkg::rgb_t      bg_i,
  input  asgr_pkg::rgb_t      def_fg_i,
  input  asgr_pkg::rgb_t      def_bg_i,
  output logic [((MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1)-1:0] raddr_o,
  input  logic [15:0]         rdata_i,
  output asgr_pkg::walk_stat_t stat_o
);

  localparam int CW = $clog2(MAX_PARAMS + 1);
  localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int XW = CW + 3;

  localparam logic [2:0] TC_NONE = 3'd0;
  localparam logic [2:0] TC_SEL  = 3'd1;
  localparam logic [2:0] TC_RED  = 3'd2;
  localparam logic [2:0] TC_GRN  = 3'd3;
  localparam logic [2:0] TC_BLU  = 3'd4;

  logic           busy_q, busy_d;
  logic [CW-1:0]  issue_q, issue_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           dv_q, dv_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [2:0]     tc_q, tc_d;
  logic           tfg_q, tfg_d;
  asgr_pkg::rgb_t f_q, f_d, g_q, g_d;
  logic [7:0]     red_q, red_d, grn_q, grn_d;

  logic           done;
  logic [15:0]    c;
  logic [15:0]    off;
  logic           room;

  assign c = rdata_i;
  assign raddr_o = issue_q[AW-1:0];
  // A truecolor code needs four more stored parameters after it.
  assign room = (XW'(idx_q) + XW'(4)) < XW'(cnt_q);
  assign done = busy_q && (issue_q == cnt_q) && !dv_q;

  always_comb begin
    busy_d  = busy_q;
    issue_d = issue_q;
    cnt_d   = cnt_q;
    dv_d    = 1'b0;
    idx_d   = idx_q;
    tc_d    = tc_q;
    tfg_d   = tfg_q;
    f_d     = f_q;
    g_d     = g_q;
    red_d   = red_q;
    grn_d   = grn_q;
    off     = '0;

    if (start_i) begin
      busy_d  = 1'b1;
      issue_d = '0;
      cnt_d   = count_i;
      tc_d    = TC_NONE;
      f_d     = fg_i;
      g_d     = bg_i;
    end else if (busy_q) begin
      if (issue_q < cnt_q) begin
        issue_d = issue_q + CW'(1);
        dv_d    = 1'b1;
        idx_d   = issue_q;
      end
      if (done) begin
        busy_d = 1'b0;
      end
    end

    if (dv_q) begin
      case (tc_q)
        TC_RED: begin
          red_d = asgr_pkg::clamp8(c);
          tc_d  = TC_GRN;
        end
        TC_GRN: begin
          grn_d = asgr_pkg::clamp8(c);
          tc_d  = TC_BLU;
        end
        TC_BLU: begin
          if (tfg_q) begin
            f_d = {red_q, grn_q, asgr_pkg::clamp8(c)};
          end else begin
            g_d = {red_q, grn_q, asgr_pkg::clamp8(c)};
          end
          tc_d = TC_NONE;
        end
        default: begin
          // In the select state a 2 opens the color triple; anything else
          // is decoded as an ordinary code.
          tc_d = TC_NONE;
          if (tc_q == TC_SEL && c == asgr_pkg::SGR_EXT_RGB) begin
            tc_d = TC_RED;
          end else if (c == asgr_pkg::SGR_RESET) begin
            f_d = def_fg_i;
            g_d = def_bg_i;
          end else if (c == asgr_pkg::SGR_FG_DEFAULT) begin
            f_d = def_fg_i;
          end else if (c == asgr_pkg::SGR_BG_DEFAULT) begin
            g_d = def_bg_i;
          end else if (c == asgr_pkg::SGR_FG_EXT || c == asgr_pkg::SGR_BG_EXT) begin
            if (room) begin
              tc_d  = TC_SEL;
              tfg_d = (c == asgr_pkg::SGR_FG_EXT);
            end
          end else if (c >= asgr_pkg::SGR_FG_BASIC && c <= asgr_pkg::SGR_FG_BASIC + 16'd7) begin
            off = c - asgr_pkg::SGR_FG_BASIC;
            f_d = asgr_pkg::pal_basic(off[2:0]);
          end else if (c >= asgr_pkg::SGR_FG_BRIGHT && c <= asgr_pkg::SGR_FG_BRIGHT + 16'd7) begin
            off = c - asgr_pkg::SGR_FG_BRIGHT;
            f_d = asgr_pkg::pal_bright(off[2:0]);
          end else if (c >= asgr_pkg::SGR_BG_BASIC && c <= asgr_pkg::SGR_BG_BASIC + 16'd7) begin
            off = c - asgr_pkg::SGR_BG_BASIC;
            g_d = asgr_pkg::pal_basic(off[2:0]);
          end else if (c >= asgr_pkg::SGR_BG_BRIGHT && c <= asgr_pkg::SGR_BG_BRIGHT + 16'd7) begin
            off = c - asgr_pkg::SGR_BG_BRIGHT;
            g_d = asgr_pkg::pal_bright(off[2:0]);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      issue_q <= '0;
      cnt_q   <= '0;
      dv_q    <= 1'b0;
      tc_q    <= TC_NONE;
    end else begin
      busy_q  <= busy_d;
      issue_q <= issue_d;
      cnt_q   <= cnt_d;
      dv_q    <= dv_d;
      tc_q    <= tc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    tfg_q <= tfg_d;
    f_q   <= f_d;
    g_q   <= g_d;
    red_q <= red_d;
    grn_q <= grn_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done;
  assign stat_o.fg   = f_q;
  assign stat_o.bg   = g_q;

endmodule

// ===== rtl/ansi_sgr_color_decoder.sv =====
// Top level of the SGR color decoder: byte parser, parameter RAM, walker and result queue.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    in_data_i  (asgr_pkg::in_t)
//   out      output     out_valid_o / out_stall_i  out_data_o (asgr_pkg::out_t)
//   cfg      input      cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// An ordinary byte, digit or separator yields zero to two results.
// A closing 'm' with stored parameters holds the input while the
// walker reads the parameter RAM one entry per cycle through its registered read port.
// Reset returns to text mode with the default colors; the parameter RAM is not cleared.
// A four-entry result queue lets input continue while up to two results wait on out_stall_i.
`timescale 1ns / 1ps
module ansi_sgr_color_decoder #(
  parameter int MAX_PARAMS  = 16,
  parameter int GLYPH_COUNT = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  asgr_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output asgr_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [23:0]     cfg_wdata_i
);

  localparam int CW = $clog2(MAX_PARAMS + 1);
  localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

  localparam logic [1:0] MODE_TEXT  = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_SEQ   = 2'd2;
  localparam logic [1:0] MODE_ABORT = 2'd3;

  localparam logic CFG_DEF_FG = 1'b0;
  localparam logic CFG_DEF_BG = 1'b1;

  logic [1:0]     mode_q, mode_d;
  logic [15:0]    acc_q, acc_d;
  logic           have_q, have_d;
  logic [CW-1:0]  pcnt_q, pcnt_d;
  asgr_pkg::rgb_t fg_q, fg_d, bg_q, bg_d;
  asgr_pkg::rgb_t def_fg_q, def_bg_q;

  asgr_pkg::walk_stat_t wstat;
  logic           walk_start;
  logic [AW-1:0]  raddr;
  logic [15:0]    rdata;
  logic           pwe;

  logic           accept;
  logic [7:0]     b;
  logic           eot;
  logic           e_esc, e_byte;
  logic [19:0]    acc_x;
  logic           push_ok;

  asgr_pkg::out_t fifo_q [4];
  logic [1:0]     wp_q, rp_q;
  logic [2:0]     fcnt_q;
  logic [1:0]     npush;
  logic           pop;
  asgr_pkg::out_t first_r, second_r;

  function automatic logic [7:0] glyph_of(input logic [7:0] v);
    return ({1'b0, v} < 9'(GLYPH_COUNT)) ? v : asgr_pkg::CHAR_QMARK;
  endfunction

  assign b      = in_data_i.char_byte;
  assign eot    = in_data_i.end_of_text;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = wstat.busy || (fcnt_q > 3'd2);

  assign acc_x   = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
                   20'(b - asgr_pkg::CHAR_ZERO);
  assign push_ok = have_q && (pcnt_q < CW'(MAX_PARAMS));

  always_comb begin
    mode_d     = mode_q;
    acc_d      = acc_q;
    have_d     = have_q;
    pcnt_d     = pcnt_q;
    fg_d       = fg_q;
    bg_d       = bg_q;
    e_esc      = 1'b0;
    e_byte     = 1'b0;
    pwe        = 1'b0;
    walk_start = 1'b0;

    if (accept) begin
      case (mode_q)
        MODE_ESC: begin
          if (b == asgr_pkg::CHAR_LBRK) begin
            mode_d = MODE_SEQ;
            acc_d  = '0;
            have_d = 1'b0;
            pcnt_d = '0;
          end else begin
            e_esc = 1'b1;
            if (b == asgr_pkg::CHAR_ESC && !eot) begin
              mode_d = MODE_ESC;
            end else begin
              e_byte = 1'b1;
              mode_d = MODE_TEXT;
            end
          end
        end
        MODE_SEQ: begin
          if (b >= asgr_pkg::CHAR_ZERO && b <= asgr_pkg::CHAR_NINE) begin
            acc_d  = (acc_x[19:16] != 4'd0) ? asgr_pkg::ACC_MAX : acc_x[15:0];
            have_d = 1'b1;
          end else if (b == asgr_pkg::CHAR_SEMI || b == asgr_pkg::CHAR_M) begin
            if (push_ok) begin
              pwe    = 1'b1;
              pcnt_d = pcnt_q + CW'(1);
            end
            acc_d  = '0;
            have_d = 1'b0;
            if (b == asgr_pkg::CHAR_M) begin
              mode_d = MODE_TEXT;
              if (pcnt_d == '0) begin
                fg_d = def_fg_q;
                bg_d = def_bg_q;
              end else begin
                // End of text reloads the defaults anyway, so no walk is needed then.
                walk_start = !eot;
              end
            end
          end else begin
            mode_d = MODE_ABORT;
          end
        end
        MODE_ABORT: begin
          mode_d = MODE_TEXT;
          if (b != asgr_pkg::CHAR_M) begin
            if (b == asgr_pkg::CHAR_ESC && !eot) begin
              mode_d = MODE_ESC;
            end else begin
              e_byte = 1'b1;
            end
          end
        end
        default: begin
          if (b == asgr_pkg::CHAR_ESC && !eot) begin
            mode_d = MODE_ESC;
          end else begin
            e_byte = 1'b1;
            mode_d = MODE_TEXT;
          end
        end
      endcase

      if (eot) begin
        fg_d   = def_fg_q;
        bg_d   = def_bg_q;
        mode_d = MODE_TEXT;
        acc_d  = '0;
        have_d = 1'b0;
        pcnt_d = '0;
      end
    end

    if (wstat.done) begin
      fg_d = wstat.fg;
      bg_d = wstat.bg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_TEXT;
      acc_q    <= '0;
      have_q   <= 1'b0;
      pcnt_q   <= '0;
      fg_q     <= asgr_pkg::FG_RESET;
      bg_q     <= asgr_pkg::BG_RESET;
      def_fg_q <= asgr_pkg::FG_RESET;
      def_bg_q <= asgr_pkg::BG_RESET;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      have_q <= have_d;
      pcnt_q <= pcnt_d;
      fg_q   <= fg_d;
      bg_q   <= bg_d;
      if (cfg_we_i && cfg_index_i == CFG_DEF_FG) begin
        def_fg_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_index_i == CFG_DEF_BG) begin
        def_bg_q <= cfg_wdata_i;
      end
    end
  end

  asgr_ram #(
    .WIDTH (16),
    .DEPTH (MAX_PARAMS)
  ) u_param_ram (
    .clk_i   (clk_i),
    .we_i    (pwe),
    .waddr_i (pcnt_q[AW-1:0]),
    .wdata_i (acc_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  asgr_walk #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (walk_start),
    .count_i  (pcnt_d),
    .fg_i     (fg_q),
    .bg_i     (bg_q),
    .def_fg_i (def_fg_q),
    .def_bg_i (def_bg_q),
    .raddr_o  (raddr),
    .rdata_i  (rdata),
    .stat_o   (wstat)
  );

  // A pending ESC goes out ahead of the byte that resolved it.
  assign npush = {1'b0, e_esc} + {1'b0, e_byte};

  always_comb begin
    first_r.glyph_code  = glyph_of(e_esc ? asgr_pkg::CHAR_ESC : b);
    first_r.fg_rgb      = fg_q;
    first_r.bg_rgb      = bg_q;
    first_r.last_of_run = (npush == 2'd1);
    second_r.glyph_code  = glyph_of(b);
    second_r.fg_rgb      = fg_q;
    second_r.bg_rgb      = bg_q;
    second_r.last_of_run = 1'b1;
  end

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (fcnt_q != 3'd0);
  assign out_data_o  = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (npush != 2'd0) begin
      fifo_q[wp_q] <= first_r;
    end
    if (npush == 2'd2) begin
      fifo_q[wp_q + 2'd1] <= second_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      fcnt_q <= '0;
    end else begin
      wp_q   <= wp_q + npush;
      rp_q   <= rp_q + {1'b0, pop};
      fcnt_q <= fcnt_q + {1'b0, npush} - {2'b00, pop};
    end
  end

endmodule

// ===== test/ansi_sgr_color_decoder_checker.sv =====
// Register names for the bench, and a checker that predicts and compares decoder glyph transfers.
`timescale 1ns / 1ps
package asgr_tb_pkg;

  typedef enum logic {REG_DEFAULT_FG, REG_DEFAULT_BG} cfg_reg_e;

endpackage

module ansi_sgr_color_decoder_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  asgr_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  asgr_pkg::out_t out_data_i,
  input  logic           cfg_we_i,
  input  logic           cfg_index_i,
  input  logic [23:0]    cfg_wdata_i,
  output int             fail_count_o,
  output int             pending_o
);
  import asgr_pkg::*;
  import asgr_tb_pkg::*;

  localparam int PARAM_SLOTS = 16;
  localparam int GLYPH_COUNT = 256;
  localparam logic [8*24-1:0] BASIC_PAL = {
    24'hE5E5E5, 24'h00CDCD, 24'hCD00CD, 24'h0000EE,
    24'hCDCD00, 24'h00CD00, 24'hCD0000, 24'h000000};
  localparam logic [8*24-1:0] BRIGHT_PAL = {
    24'hFFFFFF, 24'h00FFFF, 24'hFF00FF, 24'h5C5CFF,
    24'hFFFF00, 24'h00FF00, 24'hFF0000, 24'h7F7F7F};

  typedef enum logic [1:0] {PM_TEXT, PM_ESC, PM_SEQ, PM_ABORT} parse_mode_e;

  rgb_t        dflt_fg;
  rgb_t        dflt_bg;
  rgb_t        pen_fg;
  rgb_t        pen_bg;
  parse_mode_e mode;
  logic [15:0] accum;
  logic        got_digit;
  int          n_params;
  logic [15:0] params [PARAM_SLOTS];
  out_t        step_glyphs [$];
  out_t        glyph_q [$];
  int          fails = 0;

  function automatic void clear_params();
    accum = '0;
    got_digit = 1'b0;
    n_params = 0;
  endfunction

  function automatic void add_glyph(logic [7:0] code);
    out_t g;
    g.glyph_code = (code < GLYPH_COUNT) ? code : CHAR_QMARK;
    g.fg_rgb = pen_fg;
    g.bg_rgb = pen_bg;
    g.last_of_run = 1'b0;
    step_glyphs.push_back(g);
  endfunction

  // An ESC held back here is drawn only once the next byte shows it opens no sequence.
  function automatic void plain_byte(logic [7:0] b, logic eot);
    if (b == CHAR_ESC && !eot) begin
      mode = PM_ESC;
    end else begin
      mode = PM_TEXT;
      add_glyph(b);
    end
  endfunction

  function automatic void close_param();
    if (got_digit && n_params < PARAM_SLOTS) begin
      params[n_params] = accum;
      n_params++;
    end
    accum = '0;
    got_digit = 1'b0;
  endfunction

  function automatic logic [7:0] sat_channel(logic [15:0] v);
    return (v > 16'd255) ? 8'hFF : v[7:0];
  endfunction

  function automatic rgb_t pal_pick(logic [8*24-1:0] pal, logic [15:0] ofs);
    return pal[ofs[2:0]*24 +: 24];
  endfunction

  function automatic void apply_sgr();
    rgb_t        f;
    rgb_t        g;
    rgb_t        tc;
    logic [15:0] c;
    int          p;
    if (n_params == 0) begin
      pen_fg = dflt_fg;
      pen_bg = dflt_bg;
      return;
    end
    f = pen_fg;
    g = pen_bg;
    p = 0;
    while (p < n_params) begin
      c = params[p];
      if (c == SGR_RESET) begin
        f = dflt_fg;
        g = dflt_bg;
      end else if (c == SGR_FG_DEFAULT) begin
        f = dflt_fg;
      end else if (c == SGR_BG_DEFAULT) begin
        g = dflt_bg;
      end else if (c == SGR_FG_EXT || c == SGR_BG_EXT) begin
        // A truecolor code without its selector and three channels is skipped alone.
        if (p + 4 < n_params && params[p + 1] == SGR_EXT_RGB) begin
          tc = {sat_channel(params[p + 2]), sat_channel(params[p + 3]),
                sat_channel(params[p + 4])};
          if (c == SGR_FG_EXT) f = tc;
          else g = tc;
          p += 4;
        end
      end else if (c >= SGR_FG_BASIC && c <= SGR_FG_BASIC + 16'd7) begin
        f = pal_pick(BASIC_PAL, c - SGR_FG_BASIC);
      end else if (c >= SGR_FG_BRIGHT && c <= SGR_FG_BRIGHT + 16'd7) begin
        f = pal_pick(BRIGHT_PAL, c - SGR_FG_BRIGHT);
      end else if (c >= SGR_BG_BASIC && c <= SGR_BG_BASIC + 16'd7) begin
        g = pal_pick(BASIC_PAL, c - SGR_BG_BASIC);
      end else if (c >= SGR_BG_BRIGHT && c <= SGR_BG_BRIGHT + 16'd7) begin
        g = pal_pick(BRIGHT_PAL, c - SGR_BG_BRIGHT);
      end
      p++;
    end
    pen_fg = f;
    pen_bg = g;
  endfunction

  function automatic void decode_item(in_t item);
    logic [7:0]  b;
    logic        eot;
    int unsigned grown;
    out_t        g;
    b = item.char_byte;
    eot = item.end_of_text;
    step_glyphs.delete();
    case (mode)
      PM_ESC: begin
        if (b == CHAR_LBRK) begin
          mode = PM_SEQ;
          clear_params();
        end else begin
          add_glyph(CHAR_ESC);
          plain_byte(b, eot);
        end
      end
      PM_SEQ: begin
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
          grown = accum * 10 + (b - CHAR_ZERO);
          accum = (grown > ACC_MAX) ? ACC_MAX : grown[15:0];
          got_digit = 1'b1;
        end else if (b == CHAR_SEMI) begin
          close_param();
        end else if (b == CHAR_M) begin
          close_param();
          apply_sgr();
          mode = PM_TEXT;
        end else begin
          mode = PM_ABORT;
        end
      end
      PM_ABORT: begin
        // A closing 'm' right after an aborted sequence is dropped as well.
        mode = PM_TEXT;
        if (b != CHAR_M) plain_byte(b, eot);
      end
      default: plain_byte(b, eot);
    endcase
    foreach (step_glyphs[i]) begin
      g = step_glyphs[i];
      g.last_of_run = (i == step_glyphs.size() - 1);
      glyph_q.push_back(g);
    end
    if (eot) begin
      pen_fg = dflt_fg;
      pen_bg = dflt_bg;
      mode = PM_TEXT;
      clear_params();
    end
  endfunction

  function automatic void check_glyph(out_t got);
    out_t want;
    if (glyph_q.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("glyph transfer with nothing expected: code %h fg %h bg %h last %b",
                 got.glyph_code, got.fg_rgb, got.bg_rgb, got.last_of_run);
      return;
    end
    want = glyph_q.pop_front();
    if (got.glyph_code !== want.glyph_code || got.fg_rgb !== want.fg_rgb ||
        got.bg_rgb !== want.bg_rgb || got.last_of_run !== want.last_of_run) begin
      fails++;
      if (fails <= 10)
        $display("glyph differs: want code %h fg %h bg %h last %b, got %h %h %h %b",
                 want.glyph_code, want.fg_rgb, want.bg_rgb, want.last_of_run,
                 got.glyph_code, got.fg_rgb, got.bg_rgb, got.last_of_run);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_fg = FG_RESET;
      dflt_bg = BG_RESET;
      pen_fg = FG_RESET;
      pen_bg = BG_RESET;
      mode = PM_TEXT;
      clear_params();
      glyph_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_DEFAULT_FG) dflt_fg = cfg_wdata_i;
        else dflt_bg = cfg_wdata_i;
      end
      // Input first, so a glyph leaving on the same edge still finds its expectation.
      if (in_valid_i && !in_stall_i) decode_item(in_data_i);
      if (out_valid_i && !out_stall_i) check_glyph(out_data_i);
    end
    fail_count_o <= fails;
    pending_o <= glyph_q.size();
  end

endmodule

// ===== test/ansi_sgr_color_decoder_tb.sv =====
// Testbench top: clock, reset, byte stream and register stimulus, and the final verdict.
`timescale 1ns / 1ps
module ansi_sgr_color_decoder_tb;
  import asgr_pkg::*;
  import asgr_tb_pkg::*;

  // A closing 'm' over a full parameter store keeps the block busy while the walker reads every entry.
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 120;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [23:0] cfg_wdata_i;
  int          fail_count;
  int          pending;
  bit          calm;
  int          sent;

  ansi_sgr_color_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  ansi_sgr_color_decoder_checker glyph_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Valid stays high across back-to-back transfers; it drops only for an idle burst.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    in_t item;
    item.char_byte = b;
    item.end_of_text = eot;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic put_byte(input logic [7:0] b, input int eot_pct);
    send_byte(b, $urandom_range(0, 99) < eot_pct);
  endtask

  task automatic put_number(input int unsigned v);
    string digits;
    digits = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) put_byte(CHAR_ZERO, 1);
    for (int i = 0; i < digits.len(); i++) put_byte(digits[i], 1);
  endtask

  task automatic put_text(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) put_byte(8'($urandom_range(0, 255)), 6);
      else put_byte(8'($urandom_range(8'h20, 8'h7E)), 6);
    end
  endtask

  function automatic int unsigned pick_code();
    case ($urandom_range(0, 10))
      0: return SGR_RESET;
      1: return $urandom_range(0, 1) ? SGR_FG_DEFAULT : SGR_BG_DEFAULT;
      2: return SGR_FG_BASIC + $urandom_range(0, 7);
      3: return SGR_BG_BASIC + $urandom_range(0, 7);
      4: return SGR_FG_BRIGHT + $urandom_range(0, 7);
      5: return SGR_BG_BRIGHT + $urandom_range(0, 7);
      6: return $urandom_range(0, 120);
      7: return $urandom_range(0, 99999);
      default: return $urandom_range(0, 1) ? SGR_FG_EXT : SGR_BG_EXT;
    endcase
  endfunction

  function automatic int unsigned pick_channel();
    case ($urandom_range(0, 7))
      0: return $urandom_range(256, 1000);
      1: return $urandom_range(65530, 99999);
      2: return $urandom_range(0, 1) ? 0 : 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic put_sgr(input int n_codes);
    int unsigned code;
    int          tail;
    put_byte(CHAR_ESC, 1);
    put_byte(CHAR_LBRK, 1);
    for (int k = 0; k < n_codes; k++) begin
      if (k > 0) put_byte(CHAR_SEMI, 1);
      if ($urandom_range(0, 9) != 0) begin
        code = pick_code();
        put_number(code);
        if ((code == SGR_FG_EXT || code == SGR_BG_EXT) && $urandom_range(0, 4) != 0) begin
          // Mostly a complete truecolor group; now and then a wrong selector or short tail.
          put_byte(CHAR_SEMI, 1);
          put_number(($urandom_range(0, 5) == 0) ? $urandom_range(0, 9) : SGR_EXT_RGB);
          tail = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : 3;
          for (int j = 0; j < tail; j++) begin
            put_byte(CHAR_SEMI, 1);
            put_number(pick_channel());
          end
        end
      end
    end
    put_byte(CHAR_M, 1);
  endtask

  task automatic put_broken_sgr();
    logic [7:0] stray;
    do stray = 8'($urandom_range(0, 255));
    while ((stray >= CHAR_ZERO && stray <= CHAR_NINE) || stray == CHAR_SEMI ||
           stray == CHAR_M);
    put_byte(CHAR_ESC, 1);
    put_byte(CHAR_LBRK, 1);
    if ($urandom_range(0, 1)) put_number(pick_code());
    put_byte(stray, 3);
    if ($urandom_range(0, 1)) put_byte(CHAR_M, 3);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_defaults(input rgb_t fg, input rgb_t bg);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_DEFAULT_FG;
    cfg_wdata_i <= fg;
    @(posedge clk_i);
    cfg_index_i <= REG_DEFAULT_BG;
    cfg_wdata_i <= bg;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(input int quota);
    int start;
    start = sent;
    while (sent - start < quota) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: put_text($urandom_range(1, 6));
        16, 17: begin
          put_broken_sgr();
          put_text($urandom_range(1, 3));
        end
        18: begin
          put_byte(CHAR_ESC, 10);
          put_byte(8'($urandom_range(0, 255)), 6);
        end
        19: begin
          // Text ends in the middle of a sequence.
          put_byte(CHAR_ESC, 0);
          put_byte(CHAR_LBRK, 0);
          put_number(pick_code());
          send_byte(CHAR_SEMI, 1'b1);
        end
        default: begin
          put_sgr(($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5));
          put_text($urandom_range(1, 3));
        end
      endcase
      if ($urandom_range(0, 59) == 0) drain();
    end
    drain();
  endtask

  initial begin : sink_pacing
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= REG_DEFAULT_FG;
    cfg_wdata_i <= '0;
    calm = 1'b0;
    sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // An ESC followed by anything but '[' comes out together with that byte.
    send_byte(CHAR_ESC, 1'b0);
    send_byte("Q", 1'b0);
    // Saturating accumulator, then an empty parameter before the closing 'm'.
    send_byte(CHAR_ESC, 1'b0);
    send_byte(CHAR_LBRK, 1'b0);
    repeat (6) send_byte("9", 1'b0);
    send_byte(CHAR_SEMI, 1'b0);
    send_byte(CHAR_M, 1'b0);
    send_byte("a", 1'b0);
    // Stray byte aborts the sequence and swallows the 'm' after it.
    send_byte(CHAR_ESC, 1'b0);
    send_byte(CHAR_LBRK, 1'b0);
    send_byte("1", 1'b0);
    send_byte("x", 1'b0);
    send_byte(CHAR_M, 1'b0);
    send_byte("c", 1'b1);
    send_byte(CHAR_ESC, 1'b1);
    drain();

    set_defaults(24'h000000, 24'hFFFFFF);
    random_phase(PHASE_ITEMS);
    set_defaults(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)));
    random_phase(PHASE_ITEMS);
    calm = 1'b1;
    set_defaults(24'h000000, 24'h000000);
    random_phase(PHASE_ITEMS);
    calm = 1'b0;
    set_defaults(24'hFFFFFF, 24'hFFFFFF);
    random_phase(PHASE_ITEMS);
    set_defaults(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)));
    random_phase(PHASE_ITEMS);
    calm = 1'b1;
    set_defaults(FG_RESET, BG_RESET);
    random_phase(PHASE_ITEMS);

    if (fail_count == 0 && pending == 0) begin
      $display("ansi_sgr_color_decoder: match");
    end else begin
      $display("ansi_sgr_color_decoder: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("ansi_sgr_color_decoder: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/asgr_pkg.sv
rtl/asgr_ram.sv
rtl/asgr_walk.sv
rtl/ansi_sgr_color_decoder.sv
test/ansi_sgr_color_decoder_checker.sv
test/ansi_sgr_color_decoder_tb.sv
